[rtl/core/gripper_pick_sequencer_top_assert.svh]
// assertion macros for the gripper pick sequencer
`ifndef GRIPPER_PICK_SEQUENCER_TOP_ASSERT_SVH
`define GRIPPER_PICK_SEQUENCER_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define GPS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define GPS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[rtl/core/gps_pkg.sv]
// types, constants and step functions of the gripper pick sequencer
package gps_pkg;

   localparam int unsigned CFG_W   = 10;
   localparam int unsigned CNT_W   = 11;
   localparam int unsigned POS_W   = 12;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // request commands
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_THREE  = 3'd1;
   localparam logic [2:0] CMD_FIVE   = 3'd2;
   localparam logic [2:0] CMD_SINGLE = 3'd3;
   localparam logic [2:0] CMD_ABORT  = 3'd4;

   // sequence modes
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_THREE  = 2'd1;
   localparam logic [1:0] MODE_FIVE   = 2'd2;
   localparam logic [1:0] MODE_SINGLE = 2'd3;

   // lift requests
   localparam logic [1:0] LIFT_NONE  = 2'd0;
   localparam logic [1:0] LIFT_LOWER = 2'd1;
   localparam logic [1:0] LIFT_RAISE = 2'd2;

   // box steps
   localparam logic [2:0] BOX_FIRST  = 3'd1;
   localparam logic [2:0] BOX_SECOND = 3'd2;
   localparam logic [2:0] BOX_THIRD  = 3'd3;
   localparam logic [2:0] BOX_FOURTH = 3'd4;
   localparam logic [2:0] BOX_FIFTH  = 3'd5;
   localparam logic [2:0] BOX_SIXTH  = 3'd6;

   // grip cycle phases
   localparam logic [2:0] PHASE_CLEAR   = 3'd0;
   localparam logic [2:0] PHASE_FLIP    = 3'd1;
   localparam logic [2:0] PHASE_PINCH   = 3'd2;
   localparam logic [2:0] PHASE_LIFT    = 3'd3;
   localparam logic [2:0] PHASE_RELEASE = 3'd4;
   localparam logic [2:0] PHASE_BOUNCE  = 3'd5;

   // valve patterns, bit 0 flip, bit 1 pinch, bit 2 bounce
   localparam logic [2:0] VALVES_NONE       = 3'b000;
   localparam logic [2:0] VALVES_FLIP       = 3'b001;
   localparam logic [2:0] VALVES_FLIP_PINCH = 3'b011;
   localparam logic [2:0] VALVES_PINCH      = 3'b010;
   localparam logic [2:0] VALVES_BOUNCE     = 3'b100;

   // register indexes
   localparam logic [2:0] REG_FLIP_TIMEOUT   = 3'd0;
   localparam logic [2:0] REG_PINCH_TIMEOUT  = 3'd1;
   localparam logic [2:0] REG_LIFT_HOLD      = 3'd2;
   localparam logic [2:0] REG_RELEASE_HOLD   = 3'd3;
   localparam logic [2:0] REG_BOUNCE_TIMEOUT = 3'd4;
   localparam logic [2:0] REG_SETTLE_FOURTH  = 3'd5;
   localparam logic [2:0] REG_SETTLE_FIFTH   = 3'd6;

   // carriage stops, negative 1/16 units
   localparam logic signed [POS_W-1:0] STOP_PARK   = -12'sd568;
   localparam logic signed [POS_W-1:0] STOP_FAR    = -12'sd1096;
   localparam logic signed [POS_W-1:0] STOP_NEAR   = -12'sd80;
   localparam logic signed [POS_W-1:0] STOP_FOURTH = -12'sd328;
   localparam logic signed [POS_W-1:0] STOP_FIFTH  = -12'sd808;

   // open position windows around the magnitude of each stop
   localparam logic signed [POS_W-1:0] WIN_PARK_LO   = 12'sd480;
   localparam logic signed [POS_W-1:0] WIN_PARK_HI   = 12'sd640;
   localparam logic signed [POS_W-1:0] WIN_FAR_LO    = 12'sd960;
   localparam logic signed [POS_W-1:0] WIN_FAR_HI    = 12'sd1120;
   localparam logic signed [POS_W-1:0] WIN_NEAR_LO   = 12'sd0;
   localparam logic signed [POS_W-1:0] WIN_NEAR_HI   = 12'sd160;
   localparam logic signed [POS_W-1:0] WIN_FOURTH_LO = 12'sd240;
   localparam logic signed [POS_W-1:0] WIN_FOURTH_HI = 12'sd400;
   localparam logic signed [POS_W-1:0] WIN_FIFTH_LO  = 12'sd720;
   localparam logic signed [POS_W-1:0] WIN_FIFTH_HI  = 12'sd880;

   typedef struct packed {
      logic [CFG_W-1:0] flip_timeout;
      logic [CFG_W-1:0] pinch_timeout;
      logic [CFG_W-1:0] lift_hold_ticks;
      logic [CFG_W-1:0] release_hold_ticks;
      logic [CFG_W-1:0] bounce_timeout;
      logic [CFG_W-1:0] settle_ticks_fourth;
      logic [CFG_W-1:0] settle_ticks_fifth;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      flip_timeout:        10'd500,
      pinch_timeout:       10'd100,
      lift_hold_ticks:     10'd150,
      release_hold_ticks:  10'd100,
      bounce_timeout:      10'd100,
      settle_ticks_fourth: 10'd100,
      settle_ticks_fifth:  10'd50
   };

   typedef struct packed {
      logic [1:0]              seq_mode;
      logic [2:0]              box_step;
      logic [2:0]              visit_mark;
      logic                    grab_pending;
      logic [2:0]              phase;
      logic [CNT_W-1:0]        phase_ticks;
      logic [CNT_W-1:0]        settle_count_a;
      logic [CNT_W-1:0]        settle_count_b;
      logic signed [POS_W-1:0] target;
      logic [2:0]              valves;
   } state_type;

   localparam state_type STATE_RESET = '{
      seq_mode:       MODE_IDLE,
      box_step:       BOX_FIRST,
      visit_mark:     3'd1,
      grab_pending:   1'b0,
      phase:          PHASE_CLEAR,
      phase_ticks:    '0,
      settle_count_a: '0,
      settle_count_b: '0,
      target:         STOP_PARK,
      valves:         VALVES_NONE
   };

   typedef struct packed {
      logic                    flip_valve;
      logic                    pinch_valve;
      logic                    bounce_valve;
      logic signed [POS_W-1:0] target_position;
      logic [1:0]              lift_request;
      logic [1:0]              active_mode;
      logic [2:0]              grip_phase;
   } result_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
   endfunction

   function automatic logic in_win(input logic signed [POS_W-1:0] p,
                                   input logic signed [POS_W-1:0] lo,
                                   input logic signed [POS_W-1:0] hi);
      return (p > lo) && (p < hi);
   endfunction

   function automatic logic over(input logic [CNT_W-1:0] ticks,
                                 input logic [CFG_W-1:0] limit);
      return ticks > {1'b0, limit};
   endfunction

   // one tick of the six phase grip cycle
   function automatic state_type grip_cycle(input state_type s, input cfg_type c,
                                            input logic f, input logic p,
                                            input logic b);
      state_type r;
      r = s;
      if (!r.grab_pending) begin
         r.phase = PHASE_CLEAR;
      end else begin
         unique case (r.phase)
            PHASE_CLEAR: begin
               r.phase_ticks = sat_inc(r.phase_ticks);
               r.valves = VALVES_NONE;
               if (!f && !p && !b) begin
                  r.phase = PHASE_FLIP;
                  r.phase_ticks = '0;
               end
            end
            PHASE_FLIP: begin
               r.phase_ticks = sat_inc(r.phase_ticks);
               r.valves = VALVES_FLIP;
               if ((f && !p && !b) || over(r.phase_ticks, c.flip_timeout)) begin
                  r.phase = PHASE_PINCH;
                  r.phase_ticks = '0;
               end
            end
            PHASE_PINCH: begin
               r.phase_ticks = sat_inc(r.phase_ticks);
               r.valves = VALVES_FLIP_PINCH;
               if ((f && p && !b) || over(r.phase_ticks, c.pinch_timeout)) begin
                  r.phase = PHASE_LIFT;
                  r.phase_ticks = '0;
               end
            end
            PHASE_LIFT: begin
               r.phase_ticks = sat_inc(r.phase_ticks);
               r.valves = VALVES_PINCH;
               if (over(r.phase_ticks, c.lift_hold_ticks)) begin
                  r.phase = PHASE_RELEASE;
                  r.phase_ticks = '0;
               end
            end
            PHASE_RELEASE: begin
               r.phase_ticks = sat_inc(r.phase_ticks);
               r.valves = VALVES_PINCH;
               if (over(r.phase_ticks, c.release_hold_ticks)) begin
                  r.phase = PHASE_BOUNCE;
                  r.phase_ticks = '0;
               end
            end
            PHASE_BOUNCE: begin
               r.phase_ticks = sat_inc(r.phase_ticks);
               r.valves = VALVES_BOUNCE;
               if ((!f && !p && b) || over(r.phase_ticks, c.bounce_timeout)) begin
                  r.phase_ticks = '0;
                  r.phase = PHASE_CLEAR;
                  r.grab_pending = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   // carriage handling at one stop of the sequence
   function automatic state_type stop_step(input state_type s,
                                           input logic signed [POS_W-1:0] pos,
                                           input logic signed [POS_W-1:0] hold,
                                           input logic signed [POS_W-1:0] next,
                                           input logic signed [POS_W-1:0] hlo,
                                           input logic signed [POS_W-1:0] hhi,
                                           input logic signed [POS_W-1:0] nlo,
                                           input logic signed [POS_W-1:0] nhi,
                                           input logic [2:0] mark);
      state_type r;
      r = s;
      if (!(r.phase < PHASE_RELEASE && r.target == hold)) begin
         r.target = next;
      end
      if (in_win(pos, hlo, hhi) && r.visit_mark == mark) begin
         r.visit_mark = mark + 3'd1;
         r.grab_pending = 1'b1;
      end
      if (in_win(pos, nlo, nhi) && !r.grab_pending) begin
         r.box_step = r.box_step + 3'd1;
      end
      return r;
   endfunction

endpackage

[rtl/core/gripper_pick_sequencer_top.sv]
// gripper pick sequencer: carriage stop sequence and pneumatic grip cycle per tick
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | cmd, position, four sensors
//   rsp     | out       | rsp_valid / rsp_stall | valves, target, lift, mode, phase
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// one request per cycle while req_stall is low; its result is registered
// the tick logic is a single pass from the state registers to the result register
// a two-entry output buffer (result register plus skid) makes req_stall a flop
// reset is synchronous and loads the park state and the default timeouts
// csr_ready is always high; writes take effect on the next request
module gripper_pick_sequencer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [2:0]                      req_cmd,
   input  logic signed [gps_pkg::POS_W-1:0] req_position,
   input  logic                            req_flip_sensor,
   input  logic                            req_pinch_sensor,
   input  logic                            req_bounce_sensor,
   input  logic                            req_extend_sensor,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_flip_valve,
   output logic                            rsp_pinch_valve,
   output logic                            rsp_bounce_valve,
   output logic signed [gps_pkg::POS_W-1:0] rsp_target_position,
   output logic [1:0]                      rsp_lift_request,
   output logic [1:0]                      rsp_active_mode,
   output logic [2:0]                      rsp_grip_phase,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [2:0]                      csr_index,
   input  logic [gps_pkg::CFG_W-1:0]       csr_wdata
);

   gps_pkg::cfg_type    cfg_ff;
   gps_pkg::state_type  state_ff;
   gps_pkg::state_type  state_in;
   gps_pkg::result_type result_in;
   gps_pkg::result_type out_ff;
   gps_pkg::result_type skid_ff;
   logic [1:0]          lift_in;
   logic                rsp_valid_ff;
   logic                skid_valid_ff;
   logic                req_take;
   logic                rsp_take;
   logic                out_load;
   logic                skid_load;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_load  = !skid_valid_ff && req_take && (!rsp_valid_ff || rsp_take);
   assign skid_load = !skid_valid_ff && req_take && rsp_valid_ff && !rsp_take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= gps_pkg::CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gps_pkg::REG_FLIP_TIMEOUT:   cfg_ff.flip_timeout        <= csr_wdata;
            gps_pkg::REG_PINCH_TIMEOUT:  cfg_ff.pinch_timeout       <= csr_wdata;
            gps_pkg::REG_LIFT_HOLD:      cfg_ff.lift_hold_ticks     <= csr_wdata;
            gps_pkg::REG_RELEASE_HOLD:   cfg_ff.release_hold_ticks  <= csr_wdata;
            gps_pkg::REG_BOUNCE_TIMEOUT: cfg_ff.bounce_timeout      <= csr_wdata;
            gps_pkg::REG_SETTLE_FOURTH:  cfg_ff.settle_ticks_fourth <= csr_wdata;
            gps_pkg::REG_SETTLE_FIFTH:   cfg_ff.settle_ticks_fifth  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // one control tick
   always_comb begin
      state_in = state_ff;
      lift_in  = gps_pkg::LIFT_NONE;

      if (req_cmd == gps_pkg::CMD_THREE || req_cmd == gps_pkg::CMD_FIVE ||
          req_cmd == gps_pkg::CMD_SINGLE) begin
         state_in.seq_mode = req_cmd[1:0];
      end else if (req_cmd == gps_pkg::CMD_ABORT) begin
         state_in.seq_mode = gps_pkg::MODE_IDLE;
         lift_in = gps_pkg::LIFT_LOWER;
      end

      priority if (state_in.seq_mode == gps_pkg::MODE_IDLE) begin
         state_in.valves       = gps_pkg::VALVES_NONE;
         state_in.box_step     = gps_pkg::BOX_FIRST;
         state_in.target       = gps_pkg::STOP_PARK;
         state_in.grab_pending = 1'b0;
         state_in.phase        = gps_pkg::PHASE_CLEAR;
         state_in.visit_mark   = 3'd1;
      end else if (state_in.seq_mode == gps_pkg::MODE_SINGLE) begin
         state_in.grab_pending = 1'b1;
         state_in = gps_pkg::grip_cycle(state_in, cfg_ff, req_flip_sensor,
                                        req_pinch_sensor, req_bounce_sensor);
         if (!state_in.grab_pending) begin
            state_in.seq_mode = gps_pkg::MODE_IDLE;
         end
      end else if (state_in.box_step == gps_pkg::BOX_FIRST) begin
         state_in = gps_pkg::stop_step(state_in, req_position, gps_pkg::STOP_PARK,
                                       gps_pkg::STOP_FAR, gps_pkg::WIN_PARK_LO,
                                       gps_pkg::WIN_PARK_HI, gps_pkg::WIN_FAR_LO,
                                       gps_pkg::WIN_FAR_HI, 3'd1);
         state_in = gps_pkg::grip_cycle(state_in, cfg_ff, req_flip_sensor,
                                        req_pinch_sensor, req_bounce_sensor);
      end else if (state_in.box_step == gps_pkg::BOX_SECOND) begin
         state_in = gps_pkg::stop_step(state_in, req_position, gps_pkg::STOP_FAR,
                                       gps_pkg::STOP_NEAR, gps_pkg::WIN_FAR_LO,
                                       gps_pkg::WIN_FAR_HI, gps_pkg::WIN_NEAR_LO,
                                       gps_pkg::WIN_NEAR_HI, 3'd2);
         state_in = gps_pkg::grip_cycle(state_in, cfg_ff, req_flip_sensor,
                                        req_pinch_sensor, req_bounce_sensor);
      end else if (state_in.box_step == gps_pkg::BOX_THIRD) begin
         if (state_in.seq_mode == gps_pkg::MODE_THREE) begin
            state_in = gps_pkg::stop_step(state_in, req_position, gps_pkg::STOP_NEAR,
                                          gps_pkg::STOP_PARK, gps_pkg::WIN_NEAR_LO,
                                          gps_pkg::WIN_NEAR_HI, gps_pkg::WIN_PARK_LO,
                                          gps_pkg::WIN_PARK_HI, 3'd3);
         end else begin
            state_in = gps_pkg::stop_step(state_in, req_position, gps_pkg::STOP_NEAR,
                                          gps_pkg::STOP_FOURTH, gps_pkg::WIN_NEAR_LO,
                                          gps_pkg::WIN_NEAR_HI, gps_pkg::WIN_FOURTH_LO,
                                          gps_pkg::WIN_FOURTH_HI, 3'd3);
         end
         state_in = gps_pkg::grip_cycle(state_in, cfg_ff, req_flip_sensor,
                                        req_pinch_sensor, req_bounce_sensor);
      end else if (state_in.seq_mode == gps_pkg::MODE_THREE) begin
         if (state_in.box_step == gps_pkg::BOX_FOURTH) begin
            state_in.target = gps_pkg::STOP_PARK;
            lift_in = gps_pkg::LIFT_LOWER;
            if (gps_pkg::in_win(req_position, gps_pkg::WIN_PARK_LO,
                                gps_pkg::WIN_PARK_HI)) begin
               state_in.seq_mode = gps_pkg::MODE_IDLE;
               state_in.box_step = gps_pkg::BOX_FIRST;
            end
         end
      end else if (state_in.box_step == gps_pkg::BOX_FOURTH) begin
         lift_in = gps_pkg::LIFT_RAISE;
         state_in = gps_pkg::stop_step(state_in, req_position, gps_pkg::STOP_FOURTH,
                                       gps_pkg::STOP_FIFTH, gps_pkg::WIN_FOURTH_LO,
                                       gps_pkg::WIN_FOURTH_HI, gps_pkg::WIN_FIFTH_LO,
                                       gps_pkg::WIN_FIFTH_HI, 3'd4);
         if (!req_extend_sensor) begin
            state_in.settle_count_a = gps_pkg::sat_inc(state_in.settle_count_a);
            if (gps_pkg::over(state_in.settle_count_a, cfg_ff.settle_ticks_fourth)) begin
               state_in = gps_pkg::grip_cycle(state_in, cfg_ff, req_flip_sensor,
                                              req_pinch_sensor, req_bounce_sensor);
            end
         end else begin
            state_in.settle_count_a = '0;
         end
      end else if (state_in.box_step == gps_pkg::BOX_FIFTH) begin
         lift_in = gps_pkg::LIFT_RAISE;
         state_in = gps_pkg::stop_step(state_in, req_position, gps_pkg::STOP_FIFTH,
                                       gps_pkg::STOP_PARK, gps_pkg::WIN_FIFTH_LO,
                                       gps_pkg::WIN_FIFTH_HI, gps_pkg::WIN_PARK_LO,
                                       gps_pkg::WIN_PARK_HI, 3'd5);
         if (!req_extend_sensor) begin
            state_in.settle_count_b = gps_pkg::sat_inc(state_in.settle_count_b);
            if (gps_pkg::over(state_in.settle_count_b, cfg_ff.settle_ticks_fifth)) begin
               state_in = gps_pkg::grip_cycle(state_in, cfg_ff, req_flip_sensor,
                                              req_pinch_sensor, req_bounce_sensor);
            end
         end else begin
            state_in.settle_count_b = '0;
         end
      end else if (state_in.box_step == gps_pkg::BOX_SIXTH) begin
         lift_in = gps_pkg::LIFT_LOWER;
         state_in.target = gps_pkg::STOP_PARK;
         if (gps_pkg::in_win(req_position, gps_pkg::WIN_PARK_LO,
                             gps_pkg::WIN_PARK_HI)) begin
            state_in.seq_mode = gps_pkg::MODE_IDLE;
            state_in.box_step = gps_pkg::BOX_FIRST;
         end
      end else begin
      end

      result_in.flip_valve      = state_in.valves[0];
      result_in.pinch_valve     = state_in.valves[1];
      result_in.bounce_valve    = state_in.valves[2];
      result_in.target_position = state_in.target;
      result_in.lift_request    = lift_in;
      result_in.active_mode     = state_in.seq_mode;
      result_in.grip_phase      = state_in.phase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gps_pkg::STATE_RESET;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // result register and skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_take) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && rsp_take) begin
         out_ff <= skid_ff;
      end else if (out_load) begin
         out_ff <= result_in;
      end
      if (skid_load) begin
         skid_ff <= result_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_flip_valve      = out_ff.flip_valve;
   assign rsp_pinch_valve     = out_ff.pinch_valve;
   assign rsp_bounce_valve    = out_ff.bounce_valve;
   assign rsp_target_position = out_ff.target_position;
   assign rsp_lift_request    = out_ff.lift_request;
   assign rsp_active_mode     = out_ff.active_mode;
   assign rsp_grip_phase      = out_ff.grip_phase;

`include "gripper_pick_sequencer_top_assert.svh"

   `GPS_ASSERT_IMPLY(a_skid_behind_out, skid_valid_ff, rsp_valid_ff, "skid holds a request with empty output")
   `GPS_ASSERT_IMPLY(a_out_drop_on_take, $fell(rsp_valid_ff) && !$past(reset), !$past(rsp_stall), "result dropped while stalled")
   `GPS_ASSERT_ALWAYS(a_phase_range, state_ff.phase <= gps_pkg::PHASE_BOUNCE, "grip phase out of range")
   `GPS_ASSERT_ALWAYS(a_target_range, state_ff.target <= 12'sd0 && state_ff.target >= gps_pkg::STOP_FAR, "carriage target outside stops")

endmodule
